>>> src/rgb_to_hsi_pixel_converter_top_assert.svh
// assertion macros shared by the checker
`ifndef RGB_TO_HSI_PIXEL_CONVERTER_TOP_ASSERT_SVH
`define RGB_TO_HSI_PIXEL_CONVERTER_TOP_ASSERT_SVH

// property checked only out of reset
`define RTH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define RTH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/rgb2hsi_pkg.sv
`timescale 1ns / 1ps

package rgb2hsi_pkg;

    localparam int CORDIC_STEPS = 18;
    localparam int SQRT_STEPS   = 17;
    localparam int SQRT3_Q16    = 113512;
    localparam longint SIN_SEED = 376451350;
    localparam int XY_W         = 32;
    localparam int Z_W          = 26;
    localparam int N_W          = 35;

    typedef logic [21:0] atan_tab_t [CORDIC_STEPS];
    typedef logic [29:0] cos_tab_t [60];

    // atan(2^-i) in degrees, 16 fraction bits
    localparam atan_tab_t ATAN_TAB = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
        22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29
    };

    // cos(k - 30 deg)/sqrt(3) for k = 0..59, 30 fraction bits, rotation cordic
    function automatic cos_tab_t build_cos_tab();
        cos_tab_t tab;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        for (int k = 0; k < 60; k++)
        begin
            x = SIN_SEED;
            y = 0;
            z = (longint'(k) - 30) * 65536;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - longint'(ATAN_TAB[i]);
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + longint'(ATAN_TAB[i]);
                end
            end
            tab[k] = (x < 0) ? 30'd0 : x[29:0];
        end
        return tab;
    endfunction

    localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

>>> src/rgb_to_hsi_pixel_converter_top.sv
`timescale 1ns / 1ps
// rgb to improved-hls hue, saturation and intensity, fully pipelined
// throughput: one word per cycle; the whole pipe advances when the output
// register is empty or being taken, so s_tready = !m_tvalid || m_tready
// reset: rst_n async active low clears all valid bits, payload is not reset
module rgb_to_hsi_pixel_converter_top #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // hue_degrees[14:0], sat_value[30:15],
                                   // intensity_value[46:31], zero pad[47]
    output logic        m_tuser    // chroma_zero
);

    localparam int NST    = rgb2hsi_pkg::CORDIC_STEPS;
    localparam int XW     = rgb2hsi_pkg::XY_W;
    localparam int ZW     = rgb2hsi_pkg::Z_W;
    localparam int NW     = rgb2hsi_pkg::N_W;
    localparam int RND_SH = 16 - HUE_FRAC_BITS;
    localparam logic [25:0] RND_ADD = 26'(1) << (15 - HUE_FRAC_BITS);
    localparam logic [25:0] HUE_TOP = 26'((360 << HUE_FRAC_BITS) - 1);
    localparam logic [25:0] HUE_MAX = 26'h7FFF;
    localparam logic signed [ZW-1:0] Z_180 = ZW'(180 * 65536);
    localparam logic [24:0] FULL_TURN = 25'(360 * 65536);

    // whole pipe moves together; a stall freezes every stage
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---------------- stage 0: chroma vector, q, intensity ----------------
    logic [7:0]  red, green, blue;
    logic signed [9:0] d_rg, d_gb, d_br;
    logic [17:0] sum_sq;
    logic [16:0] q_val;
    logic [9:0]  ch_sum;
    logic [35:0] int_prod;
    logic signed [10:0] two_r;
    logic signed [XW-1:0] xa, ya;
    logic [7:0]  abs_bg;
    logic [24:0] y_mag;

    assign red   = s_tdata[7:0];
    assign green = s_tdata[15:8];
    assign blue  = s_tdata[23:16];
    assign d_rg  = $signed({2'b00, red}) - $signed({2'b00, green});
    assign d_gb  = $signed({2'b00, green}) - $signed({2'b00, blue});
    assign d_br  = $signed({2'b00, blue}) - $signed({2'b00, red});

    always_comb
    begin
        logic signed [19:0] s1, s2, s3;
        s1 = d_rg * d_rg;
        s2 = d_gb * d_gb;
        s3 = d_br * d_br;
        sum_sq = 18'(s1) + 18'(s2) + 18'(s3);
    end
    assign q_val = sum_sq[17:1];

    // (sum*512+3)/6 == (sum*256+1)/3, reciprocal of 3 in 19 fraction bits
    assign ch_sum   = 10'(red) + 10'(green) + 10'(blue);
    assign int_prod = 36'({ch_sum, 8'h01}) * 36'd174763;

    assign two_r  = $signed({2'b00, red, 1'b0}) - $signed({3'b000, green})
                    - $signed({3'b000, blue});
    assign abs_bg = (blue > green) ? (blue - green) : (green - blue);
    assign y_mag  = 25'(abs_bg) * 25'(rgb2hsi_pkg::SQRT3_Q16);
    assign xa     = XW'(two_r) <<< 16;
    assign ya     = $signed({7'b0, y_mag});

    // pipeline stage registers, index = stage
    logic                 v_reg    [NST+1];
    logic signed [XW-1:0] x_reg    [NST+1];
    logic signed [XW-1:0] y_reg    [NST+1];
    logic signed [ZW-1:0] z_reg    [NST+1];
    logic [NW-1:0]        n_reg    [NST+1];
    logic [NW-1:0]        root_reg [NST+1];
    logic                 bg_reg   [NST+1];
    logic                 cz_reg   [NST+1];
    logic [15:0]          int_reg  [NST+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // left half plane: rotate by 90 first
            if (xa < 0)
            begin
                x_reg[0] <= ya;
                y_reg[0] <= -xa;
                z_reg[0] <= ZW'(90 * 65536);
            end
            else
            begin
                x_reg[0] <= xa;
                y_reg[0] <= ya;
                z_reg[0] <= '0;
            end
            n_reg[0]    <= NW'({q_val, 16'h0000});
            root_reg[0] <= '0;
            bg_reg[0]   <= blue > green;
            cz_reg[0]   <= (red == green) && (green == blue);
            int_reg[0]  <= int_prod[34:19];
        end
    end

    // ---------------- stages 1..18: vectoring cordic and isqrt ----------------
    for (genvar gi = 0; gi < NST; gi++)
    begin : g_step
        logic signed [XW-1:0] dx, dy, x_next, y_next;
        logic signed [ZW-1:0] z_next, at;
        logic [NW-1:0]        n_next, root_next;

        assign dx = y_reg[gi] >>> gi;
        assign dy = x_reg[gi] >>> gi;
        assign at = $signed({4'b0000, rgb2hsi_pkg::ATAN_TAB[gi]});

        always_comb
        begin
            x_next = x_reg[gi];
            y_next = y_reg[gi];
            z_next = z_reg[gi];
            if (y_reg[gi] > 0)
            begin
                x_next = x_reg[gi] + dx;
                y_next = y_reg[gi] - dy;
                z_next = z_reg[gi] + at;
            end
            else if (y_reg[gi] < 0)
            begin
                x_next = x_reg[gi] - dx;
                y_next = y_reg[gi] + dy;
                z_next = z_reg[gi] - at;
            end
        end

        if (gi < rgb2hsi_pkg::SQRT_STEPS)
        begin : g_sqrt
            localparam logic [NW-1:0] BIT = NW'(1) << (32 - 2 * gi);
            always_comb
            begin
                if (n_reg[gi] >= root_reg[gi] + BIT)
                begin
                    n_next    = n_reg[gi] - (root_reg[gi] + BIT);
                    root_next = (root_reg[gi] >> 1) + BIT;
                end
                else
                begin
                    n_next    = n_reg[gi];
                    root_next = root_reg[gi] >> 1;
                end
            end
        end
        else
        begin : g_hold
            assign n_next    = n_reg[gi];
            assign root_next = root_reg[gi];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[gi+1] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[gi+1] <= v_reg[gi];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[gi+1]    <= x_next;
                y_reg[gi+1]    <= y_next;
                z_reg[gi+1]    <= z_next;
                n_reg[gi+1]    <= n_next;
                root_reg[gi+1] <= root_next;
                bg_reg[gi+1]   <= bg_reg[gi];
                cz_reg[gi+1]   <= cz_reg[gi];
                int_reg[gi+1]  <= int_reg[gi];
            end
        end
    end

    // ---------------- stage 19: clamp, mirror, round hue ----------------
    logic [24:0] hq;
    logic [25:0] h_round, h_clamp;
    logic        hv_reg;
    logic [14:0] hue_reg;
    logic [16:0] sq_a_reg;
    logic        cz_a_reg;
    logic [15:0] int_a_reg;

    always_comb
    begin
        logic [24:0] h0;
        if (z_reg[NST] < 0)
        begin
            h0 = '0;
        end
        else if (z_reg[NST] > Z_180)
        begin
            h0 = 25'(Z_180);
        end
        else
        begin
            h0 = z_reg[NST][24:0];
        end
        hq = bg_reg[NST] ? (FULL_TURN - h0) : h0;
        h_round = (26'(hq) + RND_ADD) >> RND_SH;
        h_clamp = h_round;
        if (h_clamp > HUE_TOP)
        begin
            h_clamp = HUE_TOP;
        end
        if (h_clamp > HUE_MAX)
        begin
            h_clamp = HUE_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg <= 1'b0;
        end
        else if (adv)
        begin
            hv_reg <= v_reg[NST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hue_reg   <= h_clamp[14:0];
            sq_a_reg  <= root_reg[NST][16:0];
            cz_a_reg  <= cz_reg[NST];
            int_a_reg <= int_reg[NST];
        end
    end

    // ---------------- stage 20: integer degrees modulo 60 ----------------
    logic [8:0]  h_int;
    logic [18:0] quo_prod;
    logic [2:0]  quo;
    logic [8:0]  rem_full;
    logic        kv_reg;
    logic [5:0]  k_reg;
    logic [14:0] hue_b_reg;
    logic [16:0] sq_b_reg;
    logic        cz_b_reg;
    logic [15:0] int_b_reg;

    assign h_int    = 9'(hue_reg >> HUE_FRAC_BITS);
    assign quo_prod = 19'(h_int) * 19'd547;
    assign quo      = quo_prod[17:15];
    assign rem_full = h_int - 9'(quo) * 9'd60;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kv_reg <= 1'b0;
        end
        else if (adv)
        begin
            kv_reg <= hv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k_reg     <= rem_full[5:0];
            hue_b_reg <= hue_reg;
            sq_b_reg  <= sq_a_reg;
            cz_b_reg  <= cz_a_reg;
            int_b_reg <= int_a_reg;
        end
    end

    // ---------------- stage 21: chroma times cos term ----------------
    logic        pv_reg;
    logic [46:0] prod_reg;
    logic [14:0] hue_c_reg;
    logic        cz_c_reg;
    logic [15:0] int_c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else if (adv)
        begin
            pv_reg <= kv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= 47'(sq_b_reg) * 47'(rgb2hsi_pkg::COS_TAB[k_reg]);
            hue_c_reg <= hue_b_reg;
            cz_c_reg  <= cz_b_reg;
            int_c_reg <= int_b_reg;
        end
    end

    // ---------------- stage 22: round saturation, output register ----------------
    logic [46:0] sat_round;
    logic [17:0] sat_wide;
    logic [15:0] sat_cap;
    logic        out_v_reg;
    logic [47:0] out_data_reg;
    logic        out_user_reg;

    assign sat_round = prod_reg + (47'(1) << 28);
    assign sat_wide  = sat_round[46:29];
    assign sat_cap   = (sat_wide > 18'hFFFF) ? 16'hFFFF : sat_wide[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_v_reg <= pv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (cz_c_reg)
            begin
                out_data_reg <= {1'b0, int_c_reg, 16'h0000, 15'h0000};
            end
            else
            begin
                out_data_reg <= {1'b0, int_c_reg, sat_cap, hue_c_reg};
            end
            out_user_reg <= cz_c_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

>>> src/rgb2hsi_checker.sv
`timescale 1ns / 1ps
`include "rgb_to_hsi_pixel_converter_top_assert.svh"

module rgb2hsi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    logic out_stall;
    logic ready_exp;

    assign out_stall = m_tvalid && !m_tready;
    assign ready_exp = !m_tvalid || m_tready;

    // stalled output word holds
    `RTH_ASSERT(a_out_hold, out_stall |=> (m_tvalid && $stable({m_tuser, m_tdata})), "stall lost word")

    // input side takes a word whenever the output register can move
    `RTH_ASSERT(a_ready_link, s_tready == ready_exp, "input ready not tied to output space")

    // gray pixel gives zero hue and saturation
    `RTH_ASSERT(a_gray_zero, (m_tvalid && m_tuser) |-> (m_tdata[30:0] == '0), "gray pixel not zeroed")

    // nothing leaves during reset
    `RTH_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !m_tvalid, "output valid during reset")

endmodule

bind rgb_to_hsi_pixel_converter_top rgb2hsi_checker u_rgb2hsi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;

    typedef struct {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } pixel_t;

    typedef struct {
        logic [14:0] hue_degrees;
        logic [15:0] sat_value;
        logic [15:0] intensity_value;
        logic        chroma_zero;
    } hsi_t;

    localparam int HUE_FB = 6;
    localparam int STALL_LIMIT = 4000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // red, green, blue from the lowest bit up
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // hue, saturation, intensity, pad
    logic        m_tuser;        // chroma zero

    pixel_t pending_pixels[$];
    hsi_t   expected_hsi[$];
    hsi_t   hsi_in_flight;
    int     mismatches = 0;
    int     words_sent = 0;
    int     idle_run = 0;
    bit     calm;

    always #6 clk = ~clk;

    rgb_to_hsi_pixel_converter_top #(.HUE_FRAC_BITS(HUE_FB)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic longint atan_step(int i);
        longint steps[18] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                              58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                              229, 115, 57, 29};
        return steps[i];
    endfunction

    function automatic longint chroma_angle(longint x, longint y);
        longint z;
        longint dx;
        longint dy;
        longint t;
        z = 0;
        if (x < 0)
        begin
            t = x;
            x = y;
            y = -t;
            z = 90 * 65536;
        end
        for (int i = 0; i < 18; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx; y -= dy; z += atan_step(i);
            end
            else if (y < 0)
            begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        if (z < 0) z = 0;
        if (z > 180 * 65536) z = 180 * 65536;
        return z;
    endfunction

    // cos(theta)/sqrt(3), 30 fraction bits
    function automatic longint sat_weight(longint theta);
        longint x;
        longint y;
        longint dx;
        longint dy;
        x = 376451350;
        y = 0;
        for (int i = 0; i < 18; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (theta >= 0)
            begin
                x -= dx; y += dy; theta -= atan_step(i);
            end
            else
            begin
                x += dx; y -= dy; theta += atan_step(i);
            end
        end
        return (x < 0) ? 0 : x;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic hsi_t convert_pixel(pixel_t p);
        hsi_t o;
        longint r;
        longint g;
        longint b;
        longint q;
        longint inten;
        longint hq;
        longint hf;
        longint k;
        logic [63:0] sq;
        logic [63:0] s;
        r = p.red;
        g = p.green;
        b = p.blue;
        q = ((r - g) * (r - g) + (g - b) * (g - b) + (b - r) * (b - r)) / 2;
        inten = ((r + g + b) * 512 + 3) / 6;
        if (inten > 65535) inten = 65535;
        o.intensity_value = inten[15:0];
        if (q == 0)
        begin
            o.hue_degrees = '0;
            o.sat_value = '0;
            o.chroma_zero = 1'b1;
            return o;
        end
        hq = chroma_angle((2 * r - g - b) * 65536, ((b > g) ? b - g : g - b) * 113512);
        if (b > g) hq = 360 * 65536 - hq;
        hf = (hq + (longint'(1) << (15 - HUE_FB))) >> (16 - HUE_FB);
        if (hf > (longint'(360) << HUE_FB) - 1) hf = (longint'(360) << HUE_FB) - 1;
        if (hf > 32767) hf = 32767;
        k = (hf >> HUE_FB) % 60;
        sq = int_sqrt(64'(q) << 16);
        s = (sq * 64'(sat_weight((k - 30) * 65536)) * 2 + (64'd1 << 29)) >> 30;
        if (s > 65535) s = 65535;
        o.hue_degrees = hf[14:0];
        o.sat_value = s[15:0];
        o.chroma_zero = 1'b0;
        return o;
    endfunction

    // no idling across a stretch of the run
    assign calm = (words_sent >= 300) && (words_sent < 500);

    // driver: holds a word until taken, then maybe idles
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t p;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_hsi.insert(expected_hsi.size(), hsi_in_flight);
                words_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_pixels.size() > 0 && (calm || $urandom_range(99) >= 24))
                begin
                    p = pending_pixels.pop_front();
                    hsi_in_flight = convert_pixel(p);
                    s_tvalid <= 1'b1;
                    s_tdata <= {p.blue, p.green, p.red};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor: random back-pressure and field compare
    always @(posedge clk or negedge rst_n)
    begin
        hsi_t e;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_hsi.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output word %h", m_tdata);
                end
                else
                begin
                    e = expected_hsi.pop_front();
                    if (m_tdata[14:0] !== e.hue_degrees || m_tdata[30:15] !== e.sat_value ||
                        m_tdata[46:31] !== e.intensity_value || m_tuser !== e.chroma_zero)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp h=%0d s=%0d i=%0d z=%0d",
                                     e.hue_degrees, e.sat_value, e.intensity_value,
                                     e.chroma_zero, " got h=%0d s=%0d i=%0d z=%0d",
                                     m_tdata[14:0], m_tdata[30:15],
                                     m_tdata[46:31], m_tuser);
                    end
                end
            end
            m_tready <= calm || ($urandom_range(99) >= 24);
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic queue_pixel(int r, int g, int b);
        pixel_t p;
        p.red = 8'(r);
        p.green = 8'(g);
        p.blue = 8'(b);
        pending_pixels.insert(pending_pixels.size(), p);
    endtask

    task automatic queue_random(int n);
        int v;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0:
                begin
                    v = $urandom_range(255);
                    queue_pixel(v, v, v);      // gray, zero chroma
                end
                1: queue_pixel($urandom_range(1) * 255, $urandom_range(1) * 255,
                               $urandom_range(1) * 255);
                2:
                begin
                    v = $urandom_range(255);   // near gray
                    queue_pixel(v, (v + $urandom_range(2)) % 256, v);
                end
                default: queue_pixel($urandom_range(255), $urandom_range(255),
                                     $urandom_range(255));
            endcase
        end
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() != 0 || s_tvalid || expected_hsi.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        // extremes, primaries, secondaries and hue wrap near 360
        queue_pixel(0, 0, 0);
        queue_pixel(255, 255, 255);
        queue_pixel(128, 128, 128);
        queue_pixel(255, 0, 0);
        queue_pixel(0, 255, 0);
        queue_pixel(0, 0, 255);
        queue_pixel(255, 255, 0);
        queue_pixel(0, 255, 255);
        queue_pixel(255, 0, 255);
        queue_pixel(255, 0, 1);
        queue_pixel(255, 1, 0);
        queue_pixel(1, 0, 0);
        queue_pixel(0, 1, 0);
        queue_pixel(0, 0, 1);
        queue_pixel(254, 255, 255);
        queue_pixel(170, 85, 0);
        queue_pixel(85, 170, 255);
        queue_pixel(200, 100, 100);
        queue_pixel(0, 128, 255);
        queue_pixel(255, 128, 0);
        queue_random(600);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // sender holds off until the pipe is empty
        wait_drained();
        queue_random(630);
        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> files.f
+incdir+src
src/rgb2hsi_pkg.sv
src/rgb_to_hsi_pixel_converter_top.sv
src/rgb2hsi_checker.sv
tb/tb.sv
